>>> hdl/mtc_pkg.sv
// shared types and constants for the maze turn chooser and path reducer
// no dependencies; imported by every module of the block
package mtc_pkg;

	// path store geometry
	localparam int PATH_DEPTH = 128;
	localparam int ADDR_W     = $clog2(PATH_DEPTH);
	localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

	// fixed field widths of the stream words
	localparam int IDX_W      = 7;
	localparam int CNT_OUT_W  = 8;
	localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 16;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_OBS   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// turn codes, code times 90 is the turn angle
	localparam logic [1:0] DIR_STRAIGHT = 2'd0;
	localparam logic [1:0] DIR_RIGHT    = 2'd1;
	localparam logic [1:0] DIR_BACK     = 2'd2;
	localparam logic [1:0] DIR_LEFT     = 2'd3;

	// work kinds handed from the front to the back
	typedef enum logic [2:0] {
		K_OBS   = 3'd0,
		K_FAIL  = 3'd1,
		K_END   = 3'd2,
		K_READ  = 3'd3,
		K_CLEAR = 3'd4,
		K_NOP   = 3'd5
	} op_kind_t;

	// one classified word
	typedef struct packed {
		op_kind_t           kind;
		logic [1:0]         dir;
		logic [IDX_W-1:0]   ridx;
	} op_t;

endpackage

>>> hdl/mtc_front.sv
// front end: accepts stream words, holds the hand rule and picks the turn
// depends on mtc_pkg
module mtc_front
	import mtc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// left_exit, straight_exit, right_exit, end_found, turn_ok, read_index[6:0], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]           s_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data,
	output logic                 op_valid,
	input  logic                 op_ready,
	output op_t                  op
);

	logic       hand_rule_q;
	logic       fl, fs, fr, endf, ok;
	logic [1:0] turn;

	// hand rule register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hand_rule_q <= 1'b0;
		end else if (cfg_valid) begin
			hand_rule_q <= cfg_data;
		end
	end

	assign fl   = s_tdata[0];
	assign fs   = s_tdata[1];
	assign fr   = s_tdata[2];
	assign endf = s_tdata[3];
	assign ok   = s_tdata[4];

	// turn choice by the selected hand rule, back when no exit seen
	always_comb begin
		turn = DIR_BACK;
		if (hand_rule_q) begin
			if (fr)      turn = DIR_RIGHT;
			else if (fs) turn = DIR_STRAIGHT;
			else if (fl) turn = DIR_LEFT;
		end else begin
			if (fl)      turn = DIR_LEFT;
			else if (fs) turn = DIR_STRAIGHT;
			else if (fr) turn = DIR_RIGHT;
		end
	end

	// classify the word
	always_comb begin
		op.dir  = DIR_STRAIGHT;
		op.ridx = s_tdata[5 +: IDX_W];
		case (s_tuser)
			CMD_OBS: begin
				if (endf) begin
					op.kind = K_END;
				end else begin
					op.dir  = turn;
					op.kind = ok ? K_OBS : K_FAIL;
				end
			end
			CMD_READ:  op.kind = K_READ;
			CMD_CLEAR: op.kind = K_CLEAR;
			default:   op.kind = K_NOP;
		endcase
	end

	assign op_valid = s_tvalid;
	assign s_tready = op_ready;

endmodule

>>> hdl/mtc_queue.sv
// two-entry queue of classified words between front and back
// depends on mtc_pkg
module mtc_queue
	import mtc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  in_op,
	output logic out_valid,
	input  logic out_ready,
	output op_t  out_op
);

	op_t        slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       push, pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_op    = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

endmodule

>>> hdl/mtc_back.sv
// back end: path store, stack count, fold of back turns and result register
// depends on mtc_pkg
module mtc_back
	import mtc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  op_t                  q_op,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// direction[1:0], path_count[7:0], finished, turn_failed, entry_value[1:0], zero pad
	output logic [M_TDATA_W-1:0] m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FOLD = 3'b010,
		ST_READ = 3'b100
	} back_state_t;

	back_state_t      state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q, done_d;
	logic [1:0]       top_q, top_d;
	logic [1:0]       dir_hold_q;
	logic             hit_q;

	logic [1:0]       mem [PATH_DEPTH];
	logic [1:0]       rdata_q;
	logic             wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [1:0]       wr_data;

	logic             out_valid_q;
	logic [1:0]       res_dir_q, res_val_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic             res_done_q, res_fail_q;
	logic             ld_out;
	logic [1:0]       nxt_dir, nxt_val;
	logic             nxt_fail;

	logic             take;
	logic [CNT_W-1:0] cnt_inc, cnt_dec;
	logic [1:0]       fold_sum;

	assign take     = q_valid && (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign q_ready  = take;
	assign cnt_inc  = count_q + CNT_W'(1);
	assign cnt_dec  = count_q - CNT_W'(1);
	assign fold_sum = 2'(dir_hold_q + top_q + rdata_q);

	// sequencer: most words finish in ST_IDLE; a fold or a path read goes on to ST_FOLD or ST_READ
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		done_d   = done_q;
		top_d    = top_q;
		wr_en    = 1'b0;
		wr_addr  = ADDR_W'(count_q);
		wr_data  = q_op.dir;
		rd_en    = 1'b0;
		rd_addr  = ADDR_W'(q_op.ridx);
		ld_out   = 1'b0;
		nxt_dir  = DIR_STRAIGHT;
		nxt_val  = DIR_STRAIGHT;
		nxt_fail = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (q_op.kind)
						K_OBS: begin
							if (done_q) begin
								ld_out = 1'b1;
							end else if (count_q >= CNT_W'(2) && top_q == DIR_BACK) begin
								// second newest becomes a back turn: fetch the third
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(count_q - CNT_W'(2));
								state_d = ST_FOLD;
							end else begin
								wr_en   = 1'b1;
								top_d   = q_op.dir;
								count_d = cnt_inc;
								done_d  = (cnt_inc == CNT_W'(PATH_DEPTH));
								nxt_dir = q_op.dir;
								ld_out  = 1'b1;
							end
						end
						K_FAIL: begin
							ld_out = 1'b1;
							if (!done_q) begin
								nxt_dir  = q_op.dir;
								nxt_fail = 1'b1;
							end
						end
						K_END: begin
							ld_out = 1'b1;
							if (!done_q) begin
								wr_en   = 1'b1;
								wr_data = DIR_STRAIGHT;
								top_d   = DIR_STRAIGHT;
								count_d = cnt_inc;
								done_d  = 1'b1;
							end
						end
						K_READ: begin
							rd_en   = 1'b1;
							state_d = ST_READ;
						end
						K_CLEAR: begin
							count_d = '0;
							done_d  = 1'b0;
							ld_out  = 1'b1;
						end
						default: begin
							ld_out = 1'b1;
						end
					endcase
				end
			end
			ST_FOLD: begin
				// fold three turns into one at the third newest place
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(cnt_dec - CNT_W'(1));
				wr_data = fold_sum;
				top_d   = fold_sum;
				count_d = cnt_dec;
				nxt_dir = dir_hold_q;
				ld_out  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ: begin
				nxt_val = hit_q ? rdata_q : DIR_STRAIGHT;
				ld_out  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			if (ld_out)        out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// top of stack copy and held operands
	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (take) begin
			dir_hold_q <= q_op.dir;
			hit_q      <= (CMP_W'(q_op.ridx) < CMP_W'(count_q));
		end
	end

	// path store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			res_dir_q  <= nxt_dir;
			res_cnt_q  <= count_d;
			res_done_q <= done_d;
			res_fail_q <= nxt_fail;
			res_val_q  <= nxt_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_val_q, res_fail_q, res_done_q,
		CNT_OUT_W'(res_cnt_q), res_dir_q};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PATH_DEPTH))
		else $error("path count above store depth");

	a_open_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> count_q < CNT_W'(PATH_DEPTH))
		else $error("store full but not finished");

	a_fold_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FOLD |-> (top_q == DIR_BACK && count_q >= CNT_W'(2)))
		else $error("fold started without a back turn");

	a_busy_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !out_valid_q)
		else $error("result register busy during store read");

	a_busy_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |=> (out_valid_q && state_q == ST_IDLE))
		else $error("store read did not give a result");

endmodule

>>> hdl/maze_turn_choice_and_path_reducer.sv
// Maze turn chooser and path reducer. Each intersection word picks a turn by the
// left- or right-hand rule and pushes it on a path stack; a back turn in second
// place folds the three newest turns into one. A fold or a path read goes on
// to a further back-end state, set by the single registered read port of the
// path store. A two-word queue lets the input side run ahead while a result
// waits. The store needs no clearing pass after reset.
// depends on mtc_pkg, mtc_front, mtc_queue, mtc_back
module maze_turn_choice_and_path_reducer
	import mtc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// left_exit, straight_exit, right_exit, end_found, turn_ok, read_index[6:0], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// direction[1:0], path_count[7:0], finished, turn_failed, entry_value[1:0], zero pad
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);

	logic f_valid, f_ready, b_valid, b_ready;
	op_t  f_op, b_op;

	// classify and pick the turn
	mtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op        (f_op)
	);

	// decoupling queue
	mtc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_op     (f_op),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_op    (b_op)
	);

	// path stack and results
	mtc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (b_valid),
		.q_ready  (b_ready),
		.q_op     (b_op),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> tb/sv/maze_turn_choice_and_path_reducer_test.sv
// self-checking testbench for the maze turn chooser and path reducer
// drives words with random bursts and output stalls, predicts every result word
// depends on mtc_pkg and maze_turn_choice_and_path_reducer
module maze_turn_choice_and_path_reducer_test;
	import mtc_pkg::*;

	// command code the block ignores
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int PHASE_WORDS = 450;

	// one result word, unpacked
	typedef struct packed {
		logic [1:0] turn;
		logic [7:0] count;
		logic       fin;
		logic       fail;
		logic [1:0] entry;
	} result_t;

	// one row of the directed script
	typedef struct packed {
		logic [1:0] cmd;
		logic       fl;
		logic       fs;
		logic       fr;
		logic       endf;
		logic       ok;
		logic [6:0] ridx;
		logic       lit_ok;
		result_t    lit;
	} row_t;

	localparam result_t NO_LIT = '0;
	localparam int SCRIPT_LEN = 22;

	// directed script, run under the left-hand rule right after reset
	row_t script [SCRIPT_LEN] = '{
		'{CMD_READ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b1,
			'{DIR_STRAIGHT, 8'd0, 1'b0, 1'b0, 2'd0}},
		'{CMD_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 1'b1,
			'{DIR_STRAIGHT, 8'd0, 1'b0, 1'b0, 2'd0}},
		'{CMD_OBS,   1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_OBS,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		// back turn in second place, fold to a right turn
		'{CMD_OBS,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_READ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, NO_LIT},
		// failed turn, nothing recorded
		'{CMD_OBS,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0,   1'b1,
			'{DIR_LEFT, 8'd1, 1'b0, 1'b1, 2'd0}},
		'{CMD_OBS,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 7'd5,   1'b0, NO_LIT},
		'{CMD_OBS,   1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_OBS,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_OBS,   1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_READ,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 7'd2,   1'b0, NO_LIT},
		// read past the end of the path
		'{CMD_READ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd127, 1'b1,
			'{DIR_STRAIGHT, 8'd3, 1'b0, 1'b0, 2'd0}},
		'{CMD_OBS,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, NO_LIT},
		// maze end ignores exits and a failed turn
		'{CMD_OBS,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 7'd0,   1'b0, NO_LIT},
		// observation while finished
		'{CMD_OBS,   1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_READ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd3,   1'b0, NO_LIT},
		'{CMD_CLEAR, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 7'd127, 1'b1,
			'{DIR_STRAIGHT, 8'd0, 1'b0, 1'b0, 2'd0}},
		'{CMD_READ,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b1,
			'{DIR_STRAIGHT, 8'd0, 1'b0, 1'b0, 2'd0}},
		'{CMD_OBS,   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 7'd0,   1'b0, NO_LIT},
		'{CMD_SPARE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b0, NO_LIT},
		'{CMD_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0,   1'b1,
			'{DIR_STRAIGHT, 8'd0, 1'b0, 1'b0, 2'd0}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// left_exit, straight_exit, right_exit, end_found, turn_ok, read_index[6:0], zero pad
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// cmd[1:0]
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// direction[1:0], path_count[7:0], finished, turn_failed, entry_value[1:0], zero pad
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data = 1'b0;

	// predictor state
	logic [1:0]  path_mem [PATH_DEPTH];
	int unsigned path_len = 0;
	logic        done_q = 1'b0;
	logic        rule_q = 1'b0;

	result_t pending_results [$];
	int      fault_count = 0;
	int      burst_left = 0;
	logic [7:0] ready_pat = 8'hFF;
	int      pat_age = 0;

	maze_turn_choice_and_path_reducer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	// global time limit
	initial begin
		#4000000;
		$display("maze_turn_choice_and_path_reducer_test: FAIL");
		$finish;
	end

	function automatic logic [S_TDATA_W-1:0] pack_word(logic fl, logic fs, logic fr,
			logic endf, logic ok, logic [6:0] ridx);
		return {4'b0, ridx, ok, endf, fr, fs, fl};
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// next turn and path state for one accepted word
	function automatic result_t predict_word(logic [1:0] cmd, logic [S_TDATA_W-1:0] data);
		result_t    r;
		logic [1:0] turn;
		r = '0;
		case (cmd)
			CMD_OBS: begin
				if (!done_q) begin
					if (data[3]) begin
						r.turn = DIR_STRAIGHT;
						if (path_len < PATH_DEPTH) begin
							path_mem[ADDR_W'(path_len)] = DIR_STRAIGHT;
							path_len++;
						end
						done_q = 1'b1;
					end else begin
						if (rule_q)
							turn = data[2] ? DIR_RIGHT : data[1] ? DIR_STRAIGHT :
								data[0] ? DIR_LEFT : DIR_BACK;
						else
							turn = data[0] ? DIR_LEFT : data[1] ? DIR_STRAIGHT :
								data[2] ? DIR_RIGHT : DIR_BACK;
						r.turn = turn;
						if (data[4]) begin
							if (path_len < PATH_DEPTH) begin
								path_mem[ADDR_W'(path_len)] = turn;
								path_len++;
							end
							// back turn second newest: fold three turns, angles add mod 360
							if (path_len >= 3 &&
									path_mem[ADDR_W'(path_len - 2)] == DIR_BACK) begin
								path_mem[ADDR_W'(path_len - 3)] =
									path_mem[ADDR_W'(path_len - 1)] +
									path_mem[ADDR_W'(path_len - 2)] +
									path_mem[ADDR_W'(path_len - 3)];
								path_len -= 2;
							end
							if (path_len >= PATH_DEPTH)
								done_q = 1'b1;
						end else begin
							r.fail = 1'b1;
						end
					end
				end
			end
			CMD_READ: begin
				if (data[11:5] < path_len)
					r.entry = path_mem[data[11:5]];
			end
			CMD_CLEAR: begin
				path_len = 0;
				done_q = 1'b0;
			end
			default: ;
		endcase
		r.count = path_len[7:0];
		r.fin = done_q;
		return r;
	endfunction

	// send one word in bursts with random gaps, then predict its result
	task automatic send_word(input logic [1:0] cmd, input logic [S_TDATA_W-1:0] data,
			input logic lit_ok, input result_t lit);
		result_t want;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		want = predict_word(cmd, data);
		pending_results.push_back(lit_ok ? lit : want);
	endtask

	// hold the input side until every expected word is back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_rule(input logic rule);
		cfg_valid <= 1'b1;
		cfg_data <= rule;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rule_q = rule;
	endtask

	// one exploration from a clear; a fill run aims at a full path store
	task automatic random_run(input logic fill_run, inout int sent);
		int         len;
		int         extra;
		int         pick;
		logic       back;
		logic [2:0] exits;
		logic [6:0] ridx;
		logic       endf;
		logic       ok;
		send_word(CMD_CLEAR, 16'($urandom_range(0, 4095)), 1'b0, NO_LIT);
		sent++;
		len = fill_run ? 400 : $urandom_range(8, 70);
		extra = $urandom_range(3, 8);
		for (int i = 0; i < len; i++) begin
			if (done_q) begin
				if (extra == 0)
					break;
				extra--;
			end
			pick = (!fill_run && i == len - 1) ? 99 : $urandom_range(0, 99);
			ridx = 7'($urandom_range(0, 127));
			if (pick < 2) begin
				send_word(CMD_SPARE, pack_word(rand_bit(), rand_bit(),
					rand_bit(), rand_bit(), rand_bit(), ridx),
					1'b0, NO_LIT);
				sent++;
			end else if (pick < 4 && !fill_run) begin
				send_word(CMD_CLEAR, pack_word(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, ridx),
					1'b0, NO_LIT);
				sent++;
			end else if (pick < 16) begin
				if ($urandom_range(0, 1) && path_len != 0)
					ridx = 7'($urandom_range(0, path_len > 127 ? 127 : path_len));
				send_word(CMD_READ, pack_word(rand_bit(), rand_bit(),
					rand_bit(), rand_bit(), rand_bit(), ridx),
					1'b0, NO_LIT);
				sent++;
			end else begin
				back = ($urandom_range(0, fill_run ? 15 : 3) == 0);
				exits = back ? 3'b000 : 3'($urandom_range(1, 7));
				ok = ($urandom_range(0, fill_run ? 15 : 7) != 0);
				endf = !fill_run && (i == len - 1 || $urandom_range(0, 50) == 0);
				send_word(CMD_OBS, pack_word(exits[0], exits[1], exits[2], endf, ok, ridx),
					1'b0, NO_LIT);
				sent++;
			end
		end
	endtask

	// output check and receiver stall pattern
	task automatic note_fault(input string what, input logic [7:0] want, input logic [7:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[1:0], m_tdata[9:2], m_tdata[10], m_tdata[11], m_tdata[13:12]};
			if (pending_results.size() == 0) begin
				note_fault("word with nothing expected, path_count", 8'd0, got.count);
			end else begin
				want = pending_results.pop_front();
				if (got.turn !== want.turn)
					note_fault("direction", 8'(want.turn), 8'(got.turn));
				if (got.count !== want.count)
					note_fault("path_count", want.count, got.count);
				if (got.fin !== want.fin)
					note_fault("finished", 8'(want.fin), 8'(got.fin));
				if (got.fail !== want.fail)
					note_fault("turn_failed", 8'(want.fail), 8'(got.fail));
				if (got.entry !== want.entry)
					note_fault("entry_value", 8'(want.entry), 8'(got.entry));
			end
		end
		m_tready <= ready_pat[0];
		pat_age++;
		if (pat_age >= 97) begin
			pat_age = 0;
			ready_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
		end else begin
			ready_pat <= {ready_pat[0], ready_pat[7:1]};
		end
	end

	// reset, directed script, then random phases under alternating hand rules
	initial begin
		int sent;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			send_word(script[i].cmd, pack_word(script[i].fl, script[i].fs, script[i].fr,
				script[i].endf, script[i].ok, script[i].ridx), script[i].lit_ok, script[i].lit);

		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			write_rule(phase % 2 == 0);
			sent = 0;
			random_run(1'b1, sent);
			if (phase == 1)
				wait_idle();
			while (sent < PHASE_WORDS)
				random_run($urandom_range(0, 3) == 0, sent);
		end

		wait_idle();
		if (fault_count == 0)
			$display("maze_turn_choice_and_path_reducer_test: PASS");
		else
			$display("maze_turn_choice_and_path_reducer_test: FAIL");
		$finish;
	end

endmodule
